// File: hw/rtl/nes_pkg.sv
// ----------------------------------------------------------------------------
// nes_pkg: shared types and constants of the node enrollment slave
// Opcodes, enrollment phases, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package nes_pkg;

  localparam int TimeBits  = 32;
  localparam int UidBits   = 32;
  localparam int PerBits   = 16;
  localparam int BudBits   = 3;
  localparam int BoardBits = 8;
  localparam int MstBits   = 16;
  localparam int BootBits  = 32;
  localparam int CfgBits   = 32;

  localparam int InDataBits  = 120;
  localparam int OutDataBits = 16;

  localparam logic [PerBits-1:0]   AnnouncePeriodRst = PerBits'(200);
  localparam logic [PerBits-1:0]   UnknownPeriodRst  = PerBits'(2000);
  localparam logic [BudBits-1:0]   AllowanceRst      = BudBits'(5);
  localparam logic [BoardBits-1:0] NoBoard           = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REPLY  = 2'd1,
    OP_BEACON = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    PH_BCAST    = 2'd0,
    PH_UNKNOWN  = 2'd1,
    PH_ASSIGNED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_DEVICE_UID      = 2'd0,
    REG_ANNOUNCE_PERIOD = 2'd1,
    REG_UNKNOWN_PERIOD  = 2'd2,
    REG_ALLOWANCE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [BootBits-1:0]  beacon_boots;
    logic [MstBits-1:0]   beacon_master;
    logic [BoardBits-1:0] reply_board;
    logic [UidBits-1:0]   reply_uid;
    logic [31:0]          now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           pad;
    logic [1:0]           enroll_state;
    logic [BoardBits-1:0] board_number;
    logic                 reset_request;
    logic                 send_accept;
    logic                 send_announce;
  } out_item_t;

endpackage

// File: hw/rtl/node_enrollment_slave.sv
// ----------------------------------------------------------------------------
// node_enrollment_slave: bus node enrollment, slave side
// Handles time ticks, board-number replies and master beacons; one result each.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the result stream is not stalled and returns
// one result per item: an input register holds the item, the enrollment state is
// updated by a single compare-and-select pass as the item moves into the output
// register. The 32-bit due-time add and compare on tick items sets the critical
// path. The output register lets a new item enter while a result waits to be
// taken; configuration writes are expected only while the block is idle.
module node_enrollment_slave (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [nes_pkg::CfgBits-1:0]     cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_time[31:0], reply_uid[63:32], reply_board[71:64],
  // beacon_master[87:72], beacon_boots[119:88]
  input  logic [nes_pkg::InDataBits-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                      s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // send_announce[0], send_accept[1], reset_request[2], board_number[10:3],
  // enroll_state[12:11], zeros above
  output logic [nes_pkg::OutDataBits-1:0] m_axis_tdata
);
  import nes_pkg::*;

  // configuration
  logic [UidBits-1:0] device_uid_q;
  logic [PerBits-1:0] announce_period_q, unknown_period_q;

  // enrollment state
  phase_e               phase_q, phase_d;
  logic [TimeBits-1:0]  last_announce_q, last_announce_d;
  logic [BoardBits-1:0] my_board_q, my_board_d;
  logic [MstBits-1:0]   known_master_q, known_master_d;
  logic [BootBits-1:0]  known_boots_q, known_boots_d;
  logic [BudBits-1:0]   change_budget_q, change_budget_d;

  // input register
  logic     in_valid_q;
  in_item_t in_item_q;
  opcode_e  in_op_q;

  // output register
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;

  // ---------------- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_uid_q      <= '0;
      announce_period_q <= AnnouncePeriodRst;
      unknown_period_q  <= UnknownPeriodRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DEVICE_UID:      device_uid_q      <= cfg_data_i[UidBits-1:0];
        REG_ANNOUNCE_PERIOD: announce_period_q <= cfg_data_i[PerBits-1:0];
        REG_UNKNOWN_PERIOD:  unknown_period_q  <= cfg_data_i[PerBits-1:0];
        REG_ALLOWANCE:       ;  // only reloads the change budget
      endcase
    end
  end

  // ---------------- input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_t'(s_axis_tdata);
      in_op_q   <= opcode_e'(s_axis_tuser);
    end
  end

  // ---------------- item processing
  logic [TimeBits-1:0] now_t, period_t, due_t;

  always_comb begin
    now_t    = in_item_q.now_time[TimeBits-1:0];
    period_t = (phase_q == PH_BCAST) ? TimeBits'(announce_period_q)
                                     : TimeBits'(unknown_period_q);
    due_t    = last_announce_q + period_t;
  end

  always_comb begin
    phase_d         = phase_q;
    last_announce_d = last_announce_q;
    my_board_d      = my_board_q;
    known_master_d  = known_master_q;
    known_boots_d   = known_boots_q;
    change_budget_d = change_budget_q;
    out_item_d      = '0;

    unique case (in_op_q)
      OP_TICK: begin
        if ((phase_q == PH_BCAST || phase_q == PH_UNKNOWN) && now_t > due_t) begin
          out_item_d.send_announce = 1'b1;
          last_announce_d          = now_t;
        end
      end
      OP_REPLY: begin
        if (in_item_q.reply_uid == device_uid_q &&
            !(phase_q == PH_ASSIGNED && in_item_q.reply_board != my_board_q)) begin
          if (in_item_q.reply_board != NoBoard) begin
            my_board_d             = in_item_q.reply_board;
            phase_d                = PH_ASSIGNED;
            out_item_d.send_accept = 1'b1;
          end else begin
            phase_d = PH_UNKNOWN;
          end
        end
      end
      OP_BEACON: begin
        priority if (known_master_q == '0) begin
          known_master_d = in_item_q.beacon_master;
          known_boots_d  = in_item_q.beacon_boots;
        end else if (known_master_q == in_item_q.beacon_master) begin
          out_item_d.reset_request = (known_boots_q != in_item_q.beacon_boots);
        end else if (change_budget_q == '0) begin
          out_item_d.reset_request = 1'b1;
        end else begin
          change_budget_d = change_budget_q - BudBits'(1);
        end
      end
      default: ;  // unused opcode changes nothing
    endcase

    out_item_d.board_number = my_board_d;
    out_item_d.enroll_state = phase_d;
  end

  // ---------------- state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_BCAST;
      last_announce_q <= '0;
      my_board_q      <= '0;
      known_master_q  <= '0;
      known_boots_q   <= '0;
    end else if (advance) begin
      phase_q         <= phase_d;
      last_announce_q <= last_announce_d;
      my_board_q      <= my_board_d;
      known_master_q  <= known_master_d;
      known_boots_q   <= known_boots_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_budget_q <= AllowanceRst;
    end else if (cfg_we_i && reg_idx_e'(cfg_idx_i) == REG_ALLOWANCE) begin
      // allowance write reloads the budget
      change_budget_q <= cfg_data_i[BudBits-1:0];
    end else if (advance) begin
      change_budget_q <= change_budget_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // ---------------- assertions
  a_accept_assigned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.send_accept |-> out_item_q.enroll_state == PH_ASSIGNED)
    else $error("accept flagged without assigned state");

  a_announce_unassigned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.send_announce |-> out_item_q.enroll_state != PH_ASSIGNED)
    else $error("announce flagged in assigned state");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both registers are full");

  a_budget_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_ALLOWANCE |=> change_budget_q == $past(cfg_data_i[BudBits-1:0]))
    else $error("change budget not reloaded by allowance write");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: node enrollment slave, self-checking
// Drives ticks, board-number replies and master beacons into the block over
// the input stream with random gaps, takes results with random stalls, and
// checks every result against a cycle-free model of the enrollment state
// kept in a small scoreboard. Runs through several register settings,
// walking the node from broadcasting to unknown to assigned.
// ----------------------------------------------------------------------------
module testbench;
  import nes_pkg::*;

  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam logic [15:0] HomeMaster = 16'hFFFF;
  localparam logic [31:0] HomeBoots  = 32'hFFFF_FFFF;

  typedef enum int {
    MODE_BCAST,
    MODE_UNKNOWN,
    MODE_FULL
  } drive_mode_e;

  class enroll_scoreboard;
    logic [UidBits-1:0]   uid;
    logic [PerBits-1:0]   bcast_per;
    logic [PerBits-1:0]   unk_per;
    logic [BudBits-1:0]   allowance;
    phase_e               phase;
    logic [TimeBits-1:0]  last_announce;
    logic [BoardBits-1:0] board;
    logic [MstBits-1:0]   master_id;
    logic [BootBits-1:0]  master_boots;
    logic [BudBits-1:0]   budget;
    out_item_t            status_q[$];
    int                   mismatches;

    function new();
      uid           = '0;
      bcast_per     = AnnouncePeriodRst;
      unk_per       = UnknownPeriodRst;
      allowance     = AllowanceRst;
      phase         = PH_BCAST;
      last_announce = '0;
      board         = '0;
      master_id     = '0;
      master_boots  = '0;
      budget        = AllowanceRst;
      mismatches    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CfgBits-1:0] val);
      case (idx)
        REG_DEVICE_UID:      uid = val[UidBits-1:0];
        REG_ANNOUNCE_PERIOD: bcast_per = val[PerBits-1:0];
        REG_UNKNOWN_PERIOD:  unk_per = val[PerBits-1:0];
        REG_ALLOWANCE: begin
          allowance = val[BudBits-1:0];
          budget    = val[BudBits-1:0];
        end
        default: ;
      endcase
    endfunction

    // one accepted item moves the enrollment state and queues its status word
    function void advance_enrollment(logic [1:0] op, in_item_t d);
      out_item_t            res;
      logic [TimeBits-1:0]  due;
      res = '0;
      case (op)
        OP_TICK: begin
          if (phase != PH_ASSIGNED) begin
            due = last_announce + ((phase == PH_BCAST) ? bcast_per : unk_per);
            if (d.now_time > due) begin
              res.send_announce = 1'b1;
              last_announce     = d.now_time;
            end
          end
        end
        OP_REPLY: begin
          if (d.reply_uid == uid && !(phase == PH_ASSIGNED && d.reply_board != board)) begin
            if (d.reply_board != NoBoard) begin
              board           = d.reply_board;
              phase           = PH_ASSIGNED;
              res.send_accept = 1'b1;
            end else begin
              phase = PH_UNKNOWN;
            end
          end
        end
        OP_BEACON: begin
          if (master_id == '0) begin
            master_id    = d.beacon_master;
            master_boots = d.beacon_boots;
          end else if (master_id == d.beacon_master) begin
            if (master_boots != d.beacon_boots) res.reset_request = 1'b1;
          end else if (budget == '0) begin
            res.reset_request = 1'b1;
          end else begin
            budget = budget - 3'd1;
          end
        end
        default: ;
      endcase
      res.board_number = board;
      res.enroll_state = phase;
      status_q.push_back(res);
    endfunction

    function void flag_mismatch(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: want ann=%0d acc=%0d rst=%0d board=%0d state=%0d pad=%0d",
                 $time, what, want.send_announce, want.send_accept, want.reset_request,
                 want.board_number, want.enroll_state, want.pad);
        $display("%0t %s:  got ann=%0d acc=%0d rst=%0d board=%0d state=%0d pad=%0d",
                 $time, what, got.send_announce, got.send_accept, got.reset_request,
                 got.board_number, got.enroll_state, got.pad);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (status_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
        return;
      end
      want = status_q.pop_front();
      if (got.send_announce !== want.send_announce ||
          got.send_accept !== want.send_accept ||
          got.reset_request !== want.reset_request ||
          got.board_number !== want.board_number ||
          got.enroll_state !== want.enroll_state ||
          got.pad !== want.pad) begin
        flag_mismatch("result mismatch", want, got);
      end
    endfunction

    function int outstanding();
      return status_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [1:0]             cfg_idx_i;
  logic [CfgBits-1:0]     cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;

  enroll_scoreboard sb;
  bit               tx_quiet;

  node_enrollment_slave i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input in_item_t d);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.advance_enrollment(op, d);
  endtask

  task automatic tick(input logic [31:0] t);
    in_item_t d;
    d = 120'({$urandom, $urandom, $urandom, $urandom});
    d.now_time = t;
    send_item(OP_TICK, d);
  endtask

  task automatic reply(input logic [31:0] uid, input logic [7:0] brd);
    in_item_t d;
    d = 120'({$urandom, $urandom, $urandom, $urandom});
    d.reply_uid   = uid;
    d.reply_board = brd;
    send_item(OP_REPLY, d);
  endtask

  task automatic beacon(input logic [15:0] mst, input logic [31:0] boots);
    in_item_t d;
    d = 120'({$urandom, $urandom, $urandom, $urandom});
    d.beacon_master = mst;
    d.beacon_boots  = boots;
    send_item(OP_BEACON, d);
  endtask

  // drain all outstanding results and let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // result side: random stall before each transfer, quiet stretches in between
  initial begin : result_sink
    int stall;
    int taken;
    m_axis_tready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      stall = ((taken % 100) < 15) ? 0 : $urandom_range(0, 14);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
      taken++;
    end
  end

  initial begin : stimulus
    in_item_t       d;
    logic [1:0]     op;
    int             p;
    int             i;
    int             pick;
    int             per;
    logic [31:0]    cfg_uid;
    logic [31:0]    clock_now;
    logic [15:0]    cfg_ann;
    logic [15:0]    cfg_unk;
    logic [2:0]     cfg_allow;
    drive_mode_e    mode;

    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_DEVICE_UID;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    tx_quiet      = 1'b0;
    clock_now     = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: announce timing, wrap of the due time, foreign replies,
    // unused opcode and the master beacon rules
    cfg_uid = 32'hA5C3_0F1E;
    write_reg(REG_DEVICE_UID, cfg_uid);
    write_reg(REG_ANNOUNCE_PERIOD, 32'd16);
    write_reg(REG_UNKNOWN_PERIOD, 32'hFFFF);
    write_reg(REG_ALLOWANCE, 32'd1);
    tick(32'd0);
    tick(32'd16);
    tick(32'd17);
    tick(32'hFFFF_FFFF);
    tick(32'h0000_000F);
    tick(32'h0000_0010);
    settle();
    // zero period: announce on any tick later than the last one
    write_reg(REG_ANNOUNCE_PERIOD, 32'd0);
    tick(32'h0000_0010);
    tick(32'h0000_0011);
    reply(~cfg_uid, 8'd5);
    reply(cfg_uid ^ 32'd1, NoBoard);
    send_item(OpUnused, '1);
    send_item(OpUnused, '0);
    beacon(16'h0000, 32'd123);
    beacon(HomeMaster, HomeBoots);
    beacon(HomeMaster, HomeBoots);
    beacon(HomeMaster, 32'd0);
    beacon(16'h1234, 32'd7);
    beacon(16'h1234, 32'd7);
    beacon(16'h0000, 32'd0);

    for (p = 0; p < 8; p++) begin
      settle();
      cfg_uid   = $urandom;
      cfg_ann   = 16'($urandom_range(1, 300));
      cfg_unk   = 16'($urandom);
      cfg_allow = 3'($urandom);
      case (p)
        0: begin
          cfg_uid = '0; cfg_ann = '0; cfg_unk = '0; cfg_allow = '0;
        end
        1: begin
          cfg_uid = '1; cfg_ann = '1; cfg_unk = '1; cfg_allow = 3'd7;
        end
        3: begin
          cfg_ann = 16'd200; cfg_unk = '0; cfg_allow = 3'd7;
        end
        4: begin
          cfg_unk = '1; cfg_allow = '0;
        end
        5: cfg_unk = 16'($urandom_range(1, 300));
        6: begin
          cfg_ann = '1; cfg_allow = 3'd7;
        end
        7: begin
          cfg_uid = '0; cfg_ann = '0; cfg_unk = '0;
        end
        default: ;
      endcase
      write_reg(REG_DEVICE_UID, cfg_uid);
      write_reg(REG_ANNOUNCE_PERIOD, 32'(cfg_ann));
      write_reg(REG_UNKNOWN_PERIOD, 32'(cfg_unk));
      write_reg(REG_ALLOWANCE, 32'(cfg_allow));

      mode = (p < 3) ? MODE_BCAST : (p < 6) ? MODE_UNKNOWN : MODE_FULL;
      if (p == 3) reply(cfg_uid, NoBoard);
      if (p == 6) begin
        // assignment, a conflicting number, unknown while assigned, re-confirm
        reply(cfg_uid, 8'd0);
        reply(cfg_uid, 8'd7);
        reply(cfg_uid, NoBoard);
        reply(cfg_uid, 8'd0);
        tick(32'hFFFF_FFFF);
      end
      per = (mode == MODE_BCAST) ? int'(cfg_ann) : int'(cfg_unk);

      for (i = 0; i < 200; i++) begin
        tx_quiet = (i % 64) < 12;
        d = 120'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          op = OP_TICK;
          case ($urandom_range(0, 19))
            0: clock_now = $urandom;
            1: clock_now = clock_now - 32'($urandom_range(0, per));
            default: clock_now = clock_now + 32'($urandom_range(0, 2 * per + 2));
          endcase
          d.now_time = clock_now;
        end else if (pick < 70) begin
          op = OP_REPLY;
          d.reply_uid = cfg_uid ^ ($urandom | 32'd1);
          if (mode == MODE_UNKNOWN && $urandom_range(0, 9) < 7) begin
            d.reply_uid   = cfg_uid;
            d.reply_board = NoBoard;
          end else if (mode == MODE_FULL && $urandom_range(0, 3) != 0) begin
            d.reply_uid = cfg_uid;
            case ($urandom_range(0, 4))
              0: d.reply_board = NoBoard;
              1, 2: d.reply_board = 8'd0;
              default: ;
            endcase
          end
        end else if (pick < 92) begin
          op = OP_BEACON;
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            d.beacon_master = HomeMaster;
            if ($urandom_range(0, 4) != 0) d.beacon_boots = HomeBoots;
          end else if (pick < 65) begin
            d.beacon_master = '0;
          end
        end else begin
          // noise: any opcode with random content
          op = 2'($urandom_range(0, 3));
          if (mode == MODE_BCAST && op == OP_REPLY && d.reply_uid == cfg_uid)
            d.reply_uid = ~cfg_uid;
        end
        send_item(op, d);
      end
      tx_quiet = 1'b0;
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
